/* rtl/sro_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sequence reorder buffer.
// No dependencies.
package sro_pkg;

    localparam int OP_BITS         = 2;
    localparam int SEQ_OUT_BITS    = 32;
    localparam int HANDLE_OUT_BITS = 16;

    typedef enum logic [OP_BITS-1:0] {
        OP_UNORDERED = 2'd0,
        OP_ORDERED   = 2'd1,
        OP_POLL      = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef logic [SEQ_OUT_BITS-1:0] t_seq;

endpackage

/* rtl/sro_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sro_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sequence_reorder_buffer.sv */
`timescale 1ns / 1ps
// Top level of the receive-side sequence reorder buffer.
// Depends on sro_pkg and sro_ram.

// Every accepted item yields exactly one result, shown for one cycle with
// o_strobe high; the receiver cannot stall, so results must be captured when
// strobed. An item passes through ST_IDLE, ST_READ and ST_DONE: the accept
// cycle parks a new ordered event's handle in the slot RAM, the next cycle
// reads the slot of the next expected sequence, and ST_DONE takes the RAM
// read data and forms the result, which appears on the ports in the following
// cycle. busy is high in ST_READ and ST_DONE; a new item can be accepted
// while the previous result is being strobed. The single registered read port
// of the handle RAM is why ST_DONE follows ST_READ. Slot valid bits sit in
// flip-flops and are cleared by reset; no clearing pass is needed.
module sequence_reorder_buffer
    import sro_pkg::*;
#(
    parameter int SEQ_BITS    = 7,
    parameter int HANDLE_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OP_BITS-1:0]         i_operation,
    input  logic [SEQ_BITS-1:0]        i_seq_low,
    input  logic [HANDLE_BITS-1:0]     i_event_handle,
    output logic                       o_strobe,
    output logic                       o_release_valid,
    output logic [HANDLE_OUT_BITS-1:0] o_release_handle,
    output logic [SEQ_OUT_BITS-1:0]    o_release_seq,
    output logic                       o_more_ready,
    output logic                       o_duplicate_flag
);

    localparam int WINDOW = 1 << SEQ_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } t_state;

    t_state                       r_state;
    logic [WINDOW-1:0]            r_valid;
    t_seq                         r_next_exp;
    t_op                          r_op;
    logic [HANDLE_BITS-1:0]       r_handle;
    logic                         r_dup;
    logic                         r_rel;

    logic                         r_strobe;
    logic                         r_release_valid;
    logic [HANDLE_OUT_BITS-1:0]   r_release_handle;
    t_seq                         r_release_seq;
    logic                         r_more_ready;
    logic                         r_duplicate_flag;

    logic                         accept;
    logic                         wr_en;
    logic [SEQ_BITS-1:0]          ne_idx;
    logic [SEQ_BITS-1:0]          ne_idx_inc;
    logic [HANDLE_BITS-1:0]       ram_rdata;
    logic [HANDLE_BITS+HANDLE_OUT_BITS-1:0] rd_ext;
    logic [HANDLE_BITS+HANDLE_OUT_BITS-1:0] hd_ext;

    assign busy       = (r_state != ST_IDLE);
    assign accept     = start && !busy;
    assign wr_en      = accept && (t_op'(i_operation) == OP_ORDERED) && !r_valid[i_seq_low];
    assign ne_idx     = r_next_exp[SEQ_BITS-1:0];
    assign ne_idx_inc = ne_idx + SEQ_BITS'(1);

    // Fit handles to the 16-bit result field either way round.
    assign rd_ext = {{HANDLE_OUT_BITS{1'b0}}, ram_rdata};
    assign hd_ext = {{HANDLE_OUT_BITS{1'b0}}, r_handle};

    sro_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_seq_low),
        .i_wdata (i_event_handle),
        .i_re    (r_state == ST_READ),
        .i_raddr (ne_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_next_exp <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_op     <= t_op'(i_operation);
                        r_handle <= i_event_handle;
                        r_dup    <= (t_op'(i_operation) == OP_ORDERED) && r_valid[i_seq_low];
                        if (wr_en) begin
                            r_valid[i_seq_low] <= 1'b1;
                        end
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_rel   <= ((r_op == OP_ORDERED) || (r_op == OP_POLL)) && r_valid[ne_idx];
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_strobe         <= 1'b1;
                    r_duplicate_flag <= r_dup;
                    if (r_rel) begin
                        // Release the head entry and advance.
                        r_release_valid  <= 1'b1;
                        r_release_handle <= rd_ext[HANDLE_OUT_BITS-1:0];
                        r_release_seq    <= r_next_exp;
                        r_more_ready     <= r_valid[ne_idx_inc];
                        r_valid[ne_idx]  <= 1'b0;
                        r_next_exp       <= r_next_exp + SEQ_OUT_BITS'(1);
                    end else if (r_op == OP_UNORDERED) begin
                        r_release_valid  <= 1'b1;
                        r_release_handle <= hd_ext[HANDLE_OUT_BITS-1:0];
                        r_release_seq    <= '0;
                        r_more_ready     <= r_valid[ne_idx];
                    end else begin
                        r_release_valid  <= 1'b0;
                        r_release_handle <= '0;
                        r_release_seq    <= '0;
                        r_more_ready     <= r_valid[ne_idx];
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe         = r_strobe;
    assign o_release_valid  = r_release_valid;
    assign o_release_handle = r_release_handle;
    assign o_release_seq    = r_release_seq;
    assign o_more_ready     = r_more_ready;
    assign o_duplicate_flag = r_duplicate_flag;

endmodule

/* tb/tb_sequence_reorder_buffer.sv */
`timescale 1ns / 1ps
// Self-checking bench for sequence_reorder_buffer: a release predictor in a
// small class checks every strobed result. Depends on sro_pkg and the RTL.
module tb_sequence_reorder_buffer;
    import sro_pkg::*;

    localparam int SEQ_W    = 7;
    localparam int HANDLE_W = 16;
    localparam int WINDOW   = 1 << SEQ_W;
    localparam int N_ITEMS  = 1750;
    localparam int LIMIT    = 200000;
    localparam int DRAIN    = 8;

    typedef struct packed {
        logic                valid;
        logic [HANDLE_W-1:0] handle;
        t_seq                seq;
        logic                more;
        logic                dup;
    } release_rec_t;

    class release_predictor;
        t_seq                next_exp;
        bit                  slot_valid [WINDOW];
        bit [HANDLE_W-1:0]   slot_handle [WINDOW];
        release_rec_t        pending_releases [$];
        int                  errors;
        int                  checked;

        function new();
            next_exp = '0;
            errors   = 0;
            checked  = 0;
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        endfunction

        function int pending();
            return pending_releases.size();
        endfunction

        function void report(string field, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("release %0d: %s got %0h want %0h", checked, field, got, want);
        endfunction

        function void note_item(t_op op, logic [SEQ_W-1:0] lo, logic [HANDLE_W-1:0] h);
            release_rec_t r;
            logic [SEQ_W-1:0] idx;
            r = '0;
            case (op)
                OP_UNORDERED: begin
                    r.valid  = 1'b1;
                    r.handle = h;
                end
                OP_ORDERED: begin
                    // window extension never changes the low bits: slot is seq_low
                    if (slot_valid[lo]) begin
                        r.dup = 1'b1;
                    end else begin
                        slot_valid[lo]  = 1'b1;
                        slot_handle[lo] = h;
                    end
                end
                default: ;
            endcase
            if (op == OP_ORDERED || op == OP_POLL) begin
                idx = next_exp[SEQ_W-1:0];
                if (slot_valid[idx]) begin
                    r.valid         = 1'b1;
                    r.handle        = slot_handle[idx];
                    r.seq           = next_exp;
                    slot_valid[idx] = 1'b0;
                    next_exp        = next_exp + 1;
                end
            end
            r.more = slot_valid[next_exp[SEQ_W-1:0]];
            pending_releases.push_back(r);
        endfunction

        function void check_release(release_rec_t got);
            release_rec_t want;
            checked++;
            if (pending_releases.size() == 0) begin
                report("result with no item waiting", 32'd0, 32'd0);
                return;
            end
            want = pending_releases.pop_front();
            if (got.valid !== want.valid)
                report("release_valid", 32'(got.valid), 32'(want.valid));
            if (got.handle !== want.handle)
                report("release_handle", 32'(got.handle), 32'(want.handle));
            if (got.seq !== want.seq)
                report("release_seq", got.seq, want.seq);
            if (got.more !== want.more)
                report("more_ready", 32'(got.more), 32'(want.more));
            if (got.dup !== want.dup)
                report("duplicate_flag", 32'(got.dup), 32'(want.dup));
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [OP_BITS-1:0]         i_operation = '0;
    logic [SEQ_W-1:0]           i_seq_low = '0;
    logic [HANDLE_W-1:0]        i_event_handle = '0;
    logic                       o_strobe;
    logic                       o_release_valid;
    logic [HANDLE_OUT_BITS-1:0] o_release_handle;
    logic [SEQ_OUT_BITS-1:0]    o_release_seq;
    logic                       o_more_ready;
    logic                       o_duplicate_flag;

    release_predictor preds = new();
    int               items_sent = 0;
    int               cycles = 0;
    bit               idle_ok = 1'b1;

    sequence_reorder_buffer #(
        .SEQ_BITS    (SEQ_W),
        .HANDLE_BITS (HANDLE_W)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_seq_low        (i_seq_low),
        .i_event_handle   (i_event_handle),
        .o_strobe         (o_strobe),
        .o_release_valid  (o_release_valid),
        .o_release_handle (o_release_handle),
        .o_release_seq    (o_release_seq),
        .o_more_ready     (o_more_ready),
        .o_duplicate_flag (o_duplicate_flag)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("sequence_reorder_buffer: mismatch");
            $finish;
        end
    end

    // Results are registered outputs; sample mid-cycle to stay clear of the edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1)
            preds.check_release({o_release_valid, o_release_handle, o_release_seq,
                                 o_more_ready, o_duplicate_flag});
    end

    task automatic send_item(t_op op, logic [SEQ_W-1:0] lo, logic [HANDLE_W-1:0] h);
        while (idle_ok && $urandom_range(99) < 6) begin
            start          <= 1'b0;
            i_operation    <= OP_BITS'($urandom);
            i_seq_low      <= SEQ_W'($urandom);
            i_event_handle <= HANDLE_W'($urandom);
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_operation    <= op;
        i_seq_low      <= lo;
        i_event_handle <= h;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        preds.note_item(op, lo, h);
        items_sent++;
    endtask

    task automatic wait_all_released();
        start <= 1'b0;
        @(posedge i_clk);
        while (preds.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int order [WINDOW];
        int k;
        int j;
        int tmp;
        int next_pause;
        t_seq base;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every operation, duplicates and slots at both ends of the window
        send_item(OP_UNORDERED, 7'h7F, 16'hFFFF);
        send_item(OP_UNORDERED, 7'h00, 16'h0000);
        send_item(OP_POLL, 7'h55, 16'hAAAA);
        send_item(OP_NONE, 7'h2A, 16'h5555);
        send_item(OP_ORDERED, 7'h00, 16'hFFFF);
        send_item(OP_ORDERED, 7'h02, 16'h0000);
        send_item(OP_ORDERED, 7'h02, 16'h1234);
        send_item(OP_ORDERED, 7'h01, 16'h8001);
        send_item(OP_POLL, 7'h00, 16'h0000);
        send_item(OP_POLL, 7'h7F, 16'hFFFF);
        send_item(OP_ORDERED, 7'h7F, 16'hBEEF);
        send_item(OP_ORDERED, 7'h00, 16'hCAFE);
        send_item(OP_NONE, 7'h7F, 16'hFFFF);
        send_item(OP_ORDERED, 7'h03, 16'h7FFE);
        send_item(OP_ORDERED, 7'h04, 16'h0001);
        send_item(OP_POLL, 7'h00, 16'h0000);
        send_item(OP_UNORDERED, 7'h40, 16'h8000);
        send_item(OP_ORDERED, 7'h05, 16'h00FF);
        wait_all_released();

        next_pause = 500;
        while (items_sent < N_ITEMS) begin
            idle_ok = !(items_sent > 700 && items_sent < 1100);
            if ($urandom_range(99) < 75) begin
                // well-formed burst: consecutive sequences in shuffled order
                base = preds.next_exp;
                k = ($urandom_range(19) == 0) ? $urandom_range(WINDOW, 9)
                                              : $urandom_range(8, 1);
                for (int i = 0; i < k; i++) order[i] = i;
                for (int i = k - 1; i > 0; i--) begin
                    j = $urandom_range(i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < k; i++) begin
                    if ($urandom_range(99) < 15)
                        send_item(($urandom_range(1) == 0) ? OP_UNORDERED : OP_POLL,
                                  SEQ_W'($urandom), HANDLE_W'($urandom));
                    send_item(OP_ORDERED, SEQ_W'(base + t_seq'(order[i])),
                              HANDLE_W'($urandom));
                end
                tmp = $urandom_range(k);
                for (int i = 0; i < tmp; i++)
                    send_item(OP_POLL, SEQ_W'($urandom), HANDLE_W'($urandom));
            end else begin
                // noise: any operation, any slot
                tmp = $urandom_range(6, 1);
                for (int i = 0; i < tmp; i++)
                    send_item(t_op'($urandom_range(3)), SEQ_W'($urandom),
                              HANDLE_W'($urandom));
            end
            if (items_sent >= next_pause) begin
                wait_all_released();
                next_pause += 500;
            end
        end

        wait_all_released();
        repeat (DRAIN) @(posedge i_clk);
        if (preds.errors == 0 && preds.pending() == 0)
            $display("sequence_reorder_buffer: match");
        else
            $display("sequence_reorder_buffer: mismatch");
        $finish;
    end

endmodule
